// File: src/pn3d_pkg.sv
// Package for the three-axis proportional navigation block.
// Holds the word types, register indexes, hold codes and the CORDIC arctangent table.
// No dependencies.
package pn3d_pkg;

	localparam int VEC_W    = 24;
	localparam int ANG_W    = 20;
	localparam int PITCH_W  = 18;
	localparam int RANGE_W  = 24;
	localparam int GAIN_W   = 12;
	localparam int BLIND_W  = 23;
	localparam int PLIM_W   = 17;
	localparam int YLIM_W   = 18;
	localparam int DT_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;
	localparam int CORDIC_STEPS = 17;

	localparam logic [20:0] PI_FX = 21'd205887;

	localparam logic [CFG_IDX_W-1:0] REG_NAV_GAIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLIND_RANGE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT   = 2'd3;

	localparam logic [1:0] HOLD_NONE  = 2'd0;
	localparam logic [1:0] HOLD_DEAD  = 2'd1;
	localparam logic [1:0] HOLD_BLIND = 2'd2;

	typedef enum logic {
		CLS_TRACK,
		CLS_DEAD
	} item_class_t;

	typedef struct packed {
		logic [VEC_W-1:0] rel_pos_north;
		logic [VEC_W-1:0] rel_pos_east;
		logic [VEC_W-1:0] rel_pos_down;
		logic [VEC_W-1:0] rel_vel_north;
		logic [VEC_W-1:0] rel_vel_east;
		logic [VEC_W-1:0] rel_vel_down;
		logic [VEC_W-1:0] own_vel_north;
		logic [VEC_W-1:0] own_vel_east;
		logic [VEC_W-1:0] own_vel_down;
		logic             target_alive;
		logic [DT_W-1:0]  step_time;
	} item_t;

	typedef struct packed {
		item_t       item;
		item_class_t cls;
	} entry_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  nav_gain;
		logic [BLIND_W-1:0] blind_range;
		logic [PLIM_W-1:0]  pitch_limit;
		logic [YLIM_W-1:0]  yaw_limit;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} ds_req_t;

	typedef struct packed {
		logic [PITCH_W-1:0] pitch_cmd;
		logic [ANG_W-1:0]   heading_cmd;
		logic [RANGE_W-1:0] slant_range;
		logic [1:0]         hold_reason;
	} result_t;

	typedef enum logic [5:0] {
		S_PICK, S_CLASS,
		S_NN, S_EE, S_UU, S_DEN, S_DEN_WT, S_BLIND, S_RHO_WT,
		S_VN, S_VE, S_DOT, S_RD_GO, S_RD_WT,
		S_C1, S_C2, S_C3, S_AZ_GO, S_AZ_WT,
		S_E1, S_E2, S_E3, S_EL_GO, S_EL_WT,
		S_SEED, S_O1, S_O2, S_O3, S_HS_GO, S_HS_WT,
		S_CP_GO, S_CP_WT, S_CH_GO, S_CH_WT,
		S_GD, S_P1, S_P2, S_P3, S_P4, S_OUT
	} back_state_t;

	function automatic logic [15:0] cordic_atan(input logic [4:0] i);
		logic [15:0] v;
		case (i)
			5'd0:  v = 16'd51472;
			5'd1:  v = 16'd30385;
			5'd2:  v = 16'd16055;
			5'd3:  v = 16'd8150;
			5'd4:  v = 16'd4091;
			5'd5:  v = 16'd2047;
			5'd6:  v = 16'd1024;
			5'd7:  v = 16'd512;
			5'd8:  v = 16'd256;
			5'd9:  v = 16'd128;
			5'd10: v = 16'd64;
			5'd11: v = 16'd32;
			5'd12: v = 16'd16;
			5'd13: v = 16'd8;
			5'd14: v = 16'd4;
			5'd15: v = 16'd2;
			5'd16: v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// File: src/pn3d_front.sv
// Front end: accepts guidance words into a two-entry queue and tags each as tracking or dead.
// Depends on pn3d_pkg.
module pn3d_front import pn3d_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  item_t  item,
	input  logic   q_pop,
	output logic   q_valid,
	output entry_t q_entry
);

	entry_t     ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;
	entry_t     new_ent;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;
	assign q_entry = ent_q[rd_ptr_q];

	always_comb begin
		new_ent.item = item;
		new_ent.cls  = item.target_alive ? CLS_TRACK : CLS_DEAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= new_ent;
	end

endmodule

// File: src/pn3d_divsqrt.sv
// Shared iterative unit: signed-by-unsigned truncating division, one quotient bit a cycle,
// and integer square root, one root bit a cycle. Depends on pn3d_pkg.
module pn3d_divsqrt import pn3d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ds_req_t            req,
	input  logic signed [63:0] num,
	input  logic [47:0]        den,
	input  logic [47:0]        rad,
	output logic               done,
	output logic signed [63:0] quo,
	output logic [23:0]        root
);

	logic        busy_q;
	logic        done_q;
	logic        sqrt_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [47:0] den_q;
	logic [48:0] rem_q;
	logic [63:0] n_q;
	logic [47:0] r_q;
	logic [47:0] b_q;
	logic [48:0] rem_sh;
	logic        div_ge;
	logic [47:0] trial;
	logic        sq_ge;

	assign rem_sh = {rem_q[47:0], n_q[63]};
	assign div_ge = (rem_sh >= {1'b0, den_q});
	assign trial  = r_q + b_q;
	assign sq_ge  = (n_q[47:0] >= trial);

	assign done = done_q;
	assign quo  = neg_q ? -$signed(n_q) : $signed(n_q);
	assign root = r_q[23:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.sqrt ? 6'd23 : 6'd63;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.sqrt;
			if (req.sqrt) begin
				n_q <= {16'd0, rad};
				r_q <= 48'd0;
				b_q <= 48'h4000_0000_0000;
			end else begin
				neg_q <= num[63];
				n_q   <= num[63] ? 64'(-num) : 64'(num);
				rem_q <= 49'd0;
				den_q <= den;
			end
		end else if (busy_q) begin
			if (sqrt_q) begin
				if (sq_ge) begin
					n_q <= {16'd0, n_q[47:0] - trial};
					r_q <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
			end else begin
				rem_q <= div_ge ? rem_sh - {1'b0, den_q} : rem_sh;
				n_q   <= {n_q[62:0], div_ge};
			end
		end
	end

endmodule

// File: src/pn3d_cordic.sv
// Vectoring CORDIC arctangent, one rotation a cycle over seventeen steps.
// Depends on pn3d_pkg for the arctangent table and the value of pi.
module pn3d_cordic import pn3d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [25:0] y_in,
	input  logic signed [25:0] x_in,
	output logic               done,
	output logic signed [20:0] angle
);

	logic               busy_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic signed [43:0] x_q;
	logic signed [43:0] y_q;
	logic signed [20:0] z_q;
	logic signed [43:0] x_ext;
	logic signed [43:0] y_ext;
	logic signed [43:0] xs;
	logic signed [43:0] ys;
	logic signed [20:0] at;

	assign x_ext = {{18{x_in[25]}}, x_in};
	assign y_ext = {{18{y_in[25]}}, y_in};
	assign xs    = x_q >>> cnt_q;
	assign ys    = y_q >>> cnt_q;
	assign at    = {5'd0, cordic_atan(cnt_q)};
	assign done  = done_q;
	assign angle = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 5'd0;
				if (x_in == 26'sd0 && y_in == 26'sd0) done_q <= 1'b1;
				else busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (x_in == 26'sd0 && y_in == 26'sd0) begin
				z_q <= 21'sd0;
			end else if (x_in[25]) begin
				z_q <= y_in[25] ? -$signed(PI_FX) : $signed(PI_FX);
				x_q <= (-x_ext) <<< 16;
				y_q <= (-y_ext) <<< 16;
			end else begin
				z_q <= 21'sd0;
				x_q <= x_ext <<< 16;
				y_q <= y_ext <<< 16;
			end
		end else if (busy_q) begin
			if (!y_q[43]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

endmodule

// File: src/pn3d_back.sv
// Back end: sequencer that computes range, line-of-sight rates, seeding and command update.
// Depends on pn3d_pkg, pn3d_divsqrt and pn3d_cordic; holds the output register.
module pn3d_back import pn3d_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  entry_t  q_entry,
	output logic    q_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	back_state_t        state_q, state_d;
	entry_t             cur_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic [47:0]        rho2_q;
	logic [47:0]        den_q;
	logic [23:0]        rho_q;
	logic [23:0]        h_q;
	logic signed [26:0] rhodot_q;
	logic signed [31:0] az_q;
	logic signed [31:0] el_q;
	logic [27:0]        gd_q;
	logic signed [39:0] step_q;
	logic [1:0]         reason_q;
	logic signed [18:0] pitch_q;
	logic signed [19:0] heading_q;
	logic signed [19:0] seed_q;
	logic               seeded_q;
	logic [23:0]        range_q;
	result_t            out_q;
	logic               out_full_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_full;
	ds_req_t            ds_req;
	logic signed [63:0] ds_num;
	logic [47:0]        ds_den;
	logic [47:0]        ds_rad;
	logic               ds_done;
	logic signed [63:0] ds_quo;
	logic [23:0]        ds_root;
	logic               cd_start;
	logic signed [25:0] cd_y, cd_x;
	logic               cd_done;
	logic signed [20:0] cd_angle;
	logic               blind_hit;
	logic               out_write;

	logic signed [32:0] rn, re, rup, vn, ve, vup, on, oe;
	logic signed [40:0] p_sum, p_lo, p_hi, h_sum, h_lo, h_hi;

	function automatic logic signed [32:0] sx(input logic [VEC_W-1:0] v);
		return {{(33 - VEC_W){v[VEC_W-1]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sd2147483647;
		else if (v < -64'sd2147483647) r = -32'sd2147483647;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [39:0] trunc24(input logic signed [63:0] p);
		logic signed [63:0] fl;
		logic               inc;
		fl  = p >>> 24;
		inc = p[63] && (p[23:0] != 24'd0);
		return fl[39:0] + {39'd0, inc};
	endfunction

	assign rn  = sx(cur_q.item.rel_pos_north);
	assign re  = sx(cur_q.item.rel_pos_east);
	assign rup = -sx(cur_q.item.rel_pos_down);
	assign vn  = sx(cur_q.item.rel_vel_north);
	assign ve  = sx(cur_q.item.rel_vel_east);
	assign vup = -sx(cur_q.item.rel_vel_down);
	assign on  = sx(cur_q.item.own_vel_north);
	assign oe  = sx(cur_q.item.own_vel_east);

	assign blind_hit = seeded_q && (cfg.blind_range != '0) &&
		(range_q < {1'b0, cfg.blind_range});

	assign p_sum = {{22{pitch_q[18]}}, pitch_q} + {step_q[39], step_q};
	assign p_hi  = {24'd0, cfg.pitch_limit};
	assign p_lo  = -p_hi;
	assign h_sum = {{21{heading_q[19]}}, heading_q} + {step_q[39], step_q};
	assign h_lo  = {{21{seed_q[19]}}, seed_q} - {23'd0, cfg.yaw_limit};
	assign h_hi  = {{21{seed_q[19]}}, seed_q} + {23'd0, cfg.yaw_limit};

	assign mul_full  = mul_a * mul_b;
	assign out_write = (state_q == S_OUT) && (!out_full_q || pop);
	assign empty     = !out_full_q;
	assign result    = out_q;

	pn3d_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.num    (ds_num),
		.den    (ds_den),
		.rad    (ds_rad),
		.done   (ds_done),
		.quo    (ds_quo),
		.root   (ds_root)
	);

	pn3d_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start),
		.y_in   (cd_y),
		.x_in   (cd_x),
		.done   (cd_done),
		.angle  (cd_angle)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_PICK:   if (q_valid) state_d = S_CLASS;
			S_CLASS:  state_d = (cur_q.cls == CLS_DEAD) ? S_OUT : S_NN;
			S_NN:     state_d = S_EE;
			S_EE:     state_d = S_UU;
			S_UU:     state_d = S_DEN;
			S_DEN:    state_d = S_DEN_WT;
			S_DEN_WT: if (ds_done) state_d = S_BLIND;
			S_BLIND: begin
				if (blind_hit) state_d = S_OUT;
				else if (rho2_q != 48'd0) state_d = S_RHO_WT;
				else state_d = S_SEED;
			end
			S_RHO_WT: if (ds_done) state_d = S_VN;
			S_VN:     state_d = S_VE;
			S_VE:     state_d = S_DOT;
			S_DOT:    state_d = S_RD_GO;
			S_RD_GO:  state_d = S_RD_WT;
			S_RD_WT:  if (ds_done) state_d = S_C1;
			S_C1:     state_d = S_C2;
			S_C2:     state_d = S_C3;
			S_C3:     state_d = S_AZ_GO;
			S_AZ_GO:  state_d = S_AZ_WT;
			S_AZ_WT:  if (ds_done) state_d = S_E1;
			S_E1:     state_d = S_E2;
			S_E2:     state_d = S_E3;
			S_E3:     state_d = S_EL_GO;
			S_EL_GO:  state_d = S_EL_WT;
			S_EL_WT:  if (ds_done) state_d = S_SEED;
			S_SEED:   state_d = seeded_q ? S_GD : S_O1;
			S_O1:     state_d = S_O2;
			S_O2:     state_d = S_O3;
			S_O3:     state_d = S_HS_GO;
			S_HS_GO:  state_d = S_HS_WT;
			S_HS_WT:  if (ds_done) state_d = S_CP_GO;
			S_CP_GO:  state_d = S_CP_WT;
			S_CP_WT:  if (cd_done) state_d = S_CH_GO;
			S_CH_GO:  state_d = S_CH_WT;
			S_CH_WT:  if (cd_done) state_d = S_GD;
			S_GD:     state_d = S_P1;
			S_P1:     state_d = S_P2;
			S_P2:     state_d = S_P3;
			S_P3:     state_d = S_P4;
			S_P4:     state_d = S_OUT;
			S_OUT:    if (out_write) state_d = S_PICK;
			default:  state_d = S_PICK;
		endcase
	end

	always_comb begin
		mul_a    = 33'sd0;
		mul_b    = 33'sd0;
		ds_req   = '0;
		ds_num   = acc_q;
		ds_den   = rho2_q;
		ds_rad   = rho2_q;
		cd_start = 1'b0;
		cd_y     = {oe[32], oe[24:0]};
		cd_x     = {on[32], on[24:0]};
		q_pop    = 1'b0;
		case (state_q)
			S_PICK: q_pop = q_valid;
			S_NN: begin mul_a = rn; mul_b = rn; end
			S_EE: begin mul_a = re; mul_b = re; end
			S_UU: begin mul_a = rup; mul_b = rup; end
			S_DEN: begin
				ds_req.start = 1'b1;
				ds_req.sqrt  = 1'b1;
				ds_rad       = rho2_q + prod_q[47:0];
			end
			S_BLIND: begin
				ds_req.start = !blind_hit && (rho2_q != 48'd0);
				ds_req.sqrt  = 1'b1;
			end
			S_VN: begin mul_a = rn; mul_b = vn; end
			S_VE: begin mul_a = re; mul_b = ve; end
			S_RD_GO: begin
				ds_req.start = 1'b1;
				ds_den       = {24'd0, rho_q};
			end
			S_C1: begin mul_a = rn; mul_b = ve; end
			S_C2: begin mul_a = re; mul_b = vn; end
			S_AZ_GO: begin
				ds_req.start = 1'b1;
				ds_num       = acc_q <<< 12;
			end
			S_E1: begin mul_a = {9'd0, rho_q}; mul_b = vup; end
			S_E2: begin mul_a = rup; mul_b = {{6{rhodot_q[26]}}, rhodot_q}; end
			S_EL_GO: begin
				ds_req.start = 1'b1;
				ds_num       = acc_q <<< 12;
				ds_den       = den_q;
			end
			S_O1: begin mul_a = on; mul_b = on; end
			S_O2: begin mul_a = oe; mul_b = oe; end
			S_HS_GO: begin
				ds_req.start = 1'b1;
				ds_req.sqrt  = 1'b1;
				ds_rad       = acc_q[47:0];
			end
			S_CP_GO: begin
				cd_start = 1'b1;
				cd_y     = -{{2{cur_q.item.own_vel_down[VEC_W-1]}},
					cur_q.item.own_vel_down};
				cd_x     = {2'd0, h_q};
			end
			S_CH_GO: cd_start = 1'b1;
			S_GD: begin
				mul_a = {21'd0, cfg.nav_gain};
				mul_b = {17'd0, cur_q.item.step_time};
			end
			S_P1: begin mul_a = {el_q[31], el_q}; mul_b = {5'd0, prod_q[27:0]}; end
			S_P2: begin mul_a = {az_q[31], az_q}; mul_b = {5'd0, gd_q}; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_PICK;
			out_full_q <= 1'b0;
			pitch_q    <= '0;
			heading_q  <= '0;
			seed_q     <= '0;
			seeded_q   <= 1'b0;
			range_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_write) out_full_q <= 1'b1;
			else if (pop) out_full_q <= 1'b0;
			if (state_q == S_DEN_WT && ds_done) range_q <= ds_root;
			if (state_q == S_CP_WT && cd_done) pitch_q <= cd_angle[18:0];
			if (state_q == S_CH_WT && cd_done) begin
				heading_q <= cd_angle[19:0];
				seed_q    <= cd_angle[19:0];
				seeded_q  <= 1'b1;
			end
			if (state_q == S_P3) begin
				if (p_sum < p_lo) pitch_q <= p_lo[18:0];
				else if (p_sum > p_hi) pitch_q <= p_hi[18:0];
				else pitch_q <= p_sum[18:0];
			end
			if (state_q == S_P4) begin
				if (h_sum < h_lo) heading_q <= h_lo[19:0];
				else if (h_sum > h_hi) heading_q <= h_hi[19:0];
				else heading_q <= h_sum[19:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_full[63:0];
		case (state_q)
			S_PICK:   if (q_valid) cur_q <= q_entry;
			S_CLASS:  reason_q <= HOLD_DEAD;
			S_EE:     acc_q <= prod_q;
			S_UU:     rho2_q <= acc_q[47:0] + prod_q[47:0];
			S_DEN:    den_q <= rho2_q + prod_q[47:0];
			S_BLIND: begin
				reason_q <= blind_hit ? HOLD_BLIND : HOLD_NONE;
				az_q     <= 32'sd0;
				el_q     <= 32'sd0;
			end
			S_RHO_WT: if (ds_done) rho_q <= ds_root;
			S_VE:     acc_q <= prod_q;
			S_DOT:    acc_q <= acc_q + prod_q;
			S_RD_WT:  if (ds_done) rhodot_q <= ds_quo[26:0];
			S_C2:     acc_q <= prod_q;
			S_C3:     acc_q <= acc_q - prod_q;
			S_AZ_WT:  if (ds_done) az_q <= sat32(ds_quo);
			S_E2:     acc_q <= prod_q;
			S_E3:     acc_q <= acc_q - prod_q;
			S_EL_WT:  if (ds_done) el_q <= sat32(ds_quo);
			S_O2:     acc_q <= prod_q;
			S_O3:     acc_q <= acc_q + prod_q;
			S_HS_WT:  if (ds_done) h_q <= ds_root;
			S_P1:     gd_q <= prod_q[27:0];
			S_P2:     step_q <= trunc24(prod_q);
			S_P3:     step_q <= trunc24(prod_q);
			default: ;
		endcase
		if (out_write) begin
			out_q.pitch_cmd   <= pitch_q[PITCH_W-1:0];
			out_q.heading_cmd <= heading_q;
			out_q.slant_range <= range_q;
			out_q.hold_reason <= reason_q;
		end
	end

endmodule

// File: src/pro_nav_3d_guidance.sv
// Top level of the three-axis proportional navigation block.
// Depends on pn3d_pkg, pn3d_front and pn3d_back; holds the configuration registers.
//
// Usage: words enter through push/full, one per tick unless full: relative position
// and velocity, own velocity, the target-alive flag and the step time. Each word
// gives exactly one result word on empty/pop: pitch and heading commands, the
// last slant range and the hold reason. A two-word input queue lets the front
// accept words while the back works, and a one-word output register lets the
// back start the next word while a result waits to be popped.
// Sequencing: the back works on one word at a time and takes the next only once
// the current result is written to the output register. A dead-target word skips
// all arithmetic, a blind-range hold stops after the slant-range root, an updating
// word also runs the rate divisions, and the first updating word also seeds the
// commands. The time is set by the shared divide and square-root unit, which
// produces one bit a cycle, and by the 17-step CORDIC used twice when seeding.
// Configuration writes on cfg_valid/cfg_ready are taken every cycle and are
// meant only while the block is idle. Reset loads the register defaults and
// clears the commands, range and seeding state and both queues. When the
// receiver stalls, the result holds and the back stops before writing the next.
module pro_nav_3d_guidance import pn3d_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [VEC_W-1:0] rel_pos_north,
	input  logic signed [VEC_W-1:0] rel_pos_east,
	input  logic signed [VEC_W-1:0] rel_pos_down,
	input  logic signed [VEC_W-1:0] rel_vel_north,
	input  logic signed [VEC_W-1:0] rel_vel_east,
	input  logic signed [VEC_W-1:0] rel_vel_down,
	input  logic signed [VEC_W-1:0] own_vel_north,
	input  logic signed [VEC_W-1:0] own_vel_east,
	input  logic signed [VEC_W-1:0] own_vel_down,
	input  logic                    target_alive,
	input  logic [DT_W-1:0]         step_time,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [PITCH_W-1:0] pitch_cmd,
	output logic signed [ANG_W-1:0]   heading_cmd,
	output logic [RANGE_W-1:0]        slant_range,
	output logic [1:0]                hold_reason,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	cfg_t    cfg_q;
	item_t   item;
	logic    q_pop;
	logic    q_valid;
	entry_t  q_entry;
	result_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nav_gain    <= 12'd1024;
			cfg_q.blind_range <= 23'd0;
			cfg_q.pitch_limit <= 17'd102944;
			cfg_q.yaw_limit   <= 18'd205887;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NAV_GAIN:    cfg_q.nav_gain    <= cfg_data[GAIN_W-1:0];
				REG_BLIND_RANGE: cfg_q.blind_range <= cfg_data[BLIND_W-1:0];
				REG_PITCH_LIMIT: cfg_q.pitch_limit <= cfg_data[PLIM_W-1:0];
				REG_YAW_LIMIT:   cfg_q.yaw_limit   <= cfg_data[YLIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		item.rel_pos_north = rel_pos_north;
		item.rel_pos_east  = rel_pos_east;
		item.rel_pos_down  = rel_pos_down;
		item.rel_vel_north = rel_vel_north;
		item.rel_vel_east  = rel_vel_east;
		item.rel_vel_down  = rel_vel_down;
		item.own_vel_north = own_vel_north;
		item.own_vel_east  = own_vel_east;
		item.own_vel_down  = own_vel_down;
		item.target_alive  = target_alive;
		item.step_time     = step_time;
	end

	pn3d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_pop   (q_pop),
		.q_valid (q_valid),
		.q_entry (q_entry)
	);

	pn3d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	assign pitch_cmd   = result.pitch_cmd;
	assign heading_cmd = result.heading_cmd;
	assign slant_range = result.slant_range;
	assign hold_reason = result.hold_reason;

	a_reason_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (hold_reason == HOLD_NONE || hold_reason == HOLD_DEAD ||
			hold_reason == HOLD_BLIND))
		else $error("result carries an unknown hold reason");

	a_pitch_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && hold_reason == HOLD_NONE) |->
			($signed({pitch_cmd[PITCH_W-1], pitch_cmd}) <=
				$signed({2'b00, cfg_q.pitch_limit}) &&
			$signed({pitch_cmd[PITCH_W-1], pitch_cmd}) >=
				-$signed({2'b00, cfg_q.pitch_limit})))
		else $error("updated pitch command exceeds the pitch limit");

endmodule

// File: test/pro_nav_3d_guidance_tb.sv
// Testbench for pro_nav_3d_guidance: directed guidance words, then random ones, under
// several register settings, checked word by word against a built-in guidance predictor.
// Depends on pn3d_pkg and the RTL of the block.
`timescale 1ns / 100ps

module pro_nav_3d_guidance_tb;
	import pn3d_pkg::*;

	localparam int  RAND_WORDS  = 530;
	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  DRAIN_WAIT  = 500;
	localparam longint PI_VAL   = 205887;

	typedef struct {
		item_t   word;
		bit      typed;
		result_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, cfg_ready;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	item_t drv = '0;
	logic signed [PITCH_W-1:0] pitch_cmd;
	logic signed [ANG_W-1:0] heading_cmd;
	logic [RANGE_W-1:0] slant_range;
	logic [1:0] hold_reason;

	result_t cmd_expect[$];
	row_t directed[$];
	int cycles = 0, words_in = 0, words_out = 0, errors = 0, dead_seen = 0, blind_seen = 0;
	bit finished = 0;

	longint gain_r, blind_r, plim_r, ylim_r;
	longint pitch_s, heading_s, seed_s, range_s;
	bit seeded_s;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pro_nav_3d_guidance dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.rel_pos_north(drv.rel_pos_north), .rel_pos_east(drv.rel_pos_east),
		.rel_pos_down(drv.rel_pos_down), .rel_vel_north(drv.rel_vel_north),
		.rel_vel_east(drv.rel_vel_east), .rel_vel_down(drv.rel_vel_down),
		.own_vel_north(drv.own_vel_north), .own_vel_east(drv.own_vel_east),
		.own_vel_down(drv.own_vel_down), .target_alive(drv.target_alive),
		.step_time(drv.step_time), .empty(empty), .pop(pop),
		.pitch_cmd(pitch_cmd), .heading_cmd(heading_cmd), .slant_range(slant_range),
		.hold_reason(hold_reason), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(input longint y, input longint x);
		longint z, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_VAL : -PI_VAL;
			x = -x;
			y = -y;
		end
		x = x * 65536;
		y = y * 65536;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(cordic_atan(i[4:0]));
			end else begin
				x -= ys; y += xs; z -= longint'(cordic_atan(i[4:0]));
			end
		end
		return z;
	endfunction

	function automatic longint sat_rate(input longint r);
		if (r > 64'sd2147483647) return 64'sd2147483647;
		if (r < -64'sd2147483647) return -64'sd2147483647;
		return r;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic result_t guidance_predict(input item_t w);
		longint rn, re, rup, vn, ve, vup, on, oe, od, dt;
		longint rho2, den, rho, rhodot, az, el, h;
		result_t r;
		rn = longint'(signed'(w.rel_pos_north));
		re = longint'(signed'(w.rel_pos_east));
		rup = -longint'(signed'(w.rel_pos_down));
		vn = longint'(signed'(w.rel_vel_north));
		ve = longint'(signed'(w.rel_vel_east));
		vup = -longint'(signed'(w.rel_vel_down));
		on = longint'(signed'(w.own_vel_north));
		oe = longint'(signed'(w.own_vel_east));
		od = longint'(signed'(w.own_vel_down));
		dt = longint'(w.step_time);
		r.hold_reason = HOLD_NONE;
		if (!w.target_alive) begin
			r.hold_reason = HOLD_DEAD;
		end else begin
			rho2 = rn * rn + re * re;
			den = rho2 + rup * rup;
			range_s = longint'(int_sqrt(den) & 64'hFFFFFF);
			if (seeded_s && blind_r > 0 && range_s < blind_r) begin
				r.hold_reason = HOLD_BLIND;
			end else begin
				az = 0;
				el = 0;
				if (rho2 > 0) begin
					rho = longint'(int_sqrt(rho2));
					rhodot = (rn * vn + re * ve) / rho;
					az = sat_rate(((rn * ve - re * vn) * 4096) / rho2);
					el = sat_rate(((rho * vup - rup * rhodot) * 4096) / den);
				end
				if (!seeded_s) begin
					h = longint'(int_sqrt(on * on + oe * oe));
					pitch_s = vector_angle(-od, h);
					heading_s = vector_angle(oe, on);
					seed_s = heading_s;
					seeded_s = 1;
				end
				pitch_s = clamp(pitch_s + (el * gain_r * dt) / 16777216, -plim_r, plim_r);
				heading_s = clamp(heading_s + (az * gain_r * dt) / 16777216,
					seed_s - ylim_r, seed_s + ylim_r);
			end
		end
		r.pitch_cmd = pitch_s[PITCH_W-1:0];
		r.heading_cmd = heading_s[ANG_W-1:0];
		r.slant_range = range_s[RANGE_W-1:0];
		return r;
	endfunction

	function automatic logic [VEC_W-1:0] rand_vec(input int kind);
		case (kind)
			0: return VEC_W'($urandom);
			1: return VEC_W'($urandom_range(0, 8192)) - VEC_W'(4096);
			default: return VEC_W'($urandom_range(0, 1 << 19)) - VEC_W'(1 << 18);
		endcase
	endfunction

	function automatic item_t rand_word();
		item_t w;
		int kind;
		kind = $urandom_range(0, 3);
		w.rel_pos_north = (kind == 3) ? '0 : rand_vec(kind);
		w.rel_pos_east = (kind == 3) ? '0 : rand_vec(kind);
		w.rel_pos_down = rand_vec(kind % 3);
		w.rel_vel_north = rand_vec($urandom_range(0, 2));
		w.rel_vel_east = rand_vec($urandom_range(0, 2));
		w.rel_vel_down = rand_vec($urandom_range(0, 2));
		w.own_vel_north = VEC_W'($urandom);
		w.own_vel_east = VEC_W'($urandom);
		w.own_vel_down = VEC_W'($urandom);
		w.target_alive = ($urandom_range(0, 9) != 0);
		w.step_time = ($urandom_range(0, 1) != 0) ? DT_W'($urandom_range(0, 2000))
			: DT_W'($urandom);
		return w;
	endfunction

	function automatic item_t mk(input longint pn, pe, pd, vn, ve, vd, on, oe, od,
		input bit alive, input int dt);
		item_t w;
		w.rel_pos_north = pn[VEC_W-1:0];
		w.rel_pos_east = pe[VEC_W-1:0];
		w.rel_pos_down = pd[VEC_W-1:0];
		w.rel_vel_north = vn[VEC_W-1:0];
		w.rel_vel_east = ve[VEC_W-1:0];
		w.rel_vel_down = vd[VEC_W-1:0];
		w.own_vel_north = on[VEC_W-1:0];
		w.own_vel_east = oe[VEC_W-1:0];
		w.own_vel_down = od[VEC_W-1:0];
		w.target_alive = alive;
		w.step_time = dt[DT_W-1:0];
		return w;
	endfunction

	task automatic add_row(input item_t w, input bit typed, input result_t res);
		row_t r;
		r.word = w;
		r.typed = typed;
		r.res = res;
		directed.push_back(r);
	endtask

	task automatic send_word(input item_t w, input bit typed, input result_t res);
		result_t p;
		@(negedge clk);
		drv = w;
		push = 1'b1;
		do @(posedge clk); while (full);
		p = guidance_predict(w);
		cmd_expect.push_back(typed ? res : p);
		words_in++;
		if ($urandom_range(0, 3) == 0) begin
			@(negedge clk);
			push = 1'b0;
			repeat ($urandom_range(0, 40)) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
		@(negedge clk);
		push = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_NAV_GAIN: gain_r = val & 64'hFFF;
			REG_BLIND_RANGE: blind_r = val & 64'h7FFFFF;
			REG_PITCH_LIMIT: plim_r = val & 64'h1FFFF;
			default: ylim_r = val & 64'h3FFFF;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (cmd_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_regs(input longint g, input longint b, input longint p, input longint y);
		settle();
		write_reg(REG_NAV_GAIN, g);
		write_reg(REG_BLIND_RANGE, b);
		write_reg(REG_PITCH_LIMIT, p);
		write_reg(REG_YAW_LIMIT, y);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT && !finished) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	int stall_mode = 0;
	always @(negedge clk) begin
		if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 1) != 0);
			default: pop <= ($urandom_range(0, 15) == 0);
		endcase
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && pop && !empty) begin
			words_out++;
			if (hold_reason == HOLD_DEAD) dead_seen++;
			if (hold_reason == HOLD_BLIND) blind_seen++;
			if (cmd_expect.size() == 0) begin
				$display("%0t: result word with none expected", $time);
				errors++;
			end else begin
				e = cmd_expect.pop_front();
				if (pitch_cmd !== e.pitch_cmd) begin
					$display("%0t: pitch_cmd exp %h got %h", $time, e.pitch_cmd, pitch_cmd);
					errors++;
				end
				if (heading_cmd !== e.heading_cmd) begin
					$display("%0t: heading_cmd exp %h got %h", $time, e.heading_cmd,
						heading_cmd);
					errors++;
				end
				if (slant_range !== e.slant_range) begin
					$display("%0t: slant_range exp %h got %h", $time, e.slant_range,
						slant_range);
					errors++;
				end
				if (hold_reason !== e.hold_reason) begin
					$display("%0t: hold_reason exp %h got %h", $time, e.hold_reason,
						hold_reason);
					errors++;
				end
			end
		end
	end

	initial begin
		result_t z;
		longint mx, mn;
		mx = 8388607;
		mn = -8388608;
		gain_r = 1024; blind_r = 0; plim_r = 102944; ylim_r = 205887;
		pitch_s = 0; heading_s = 0; seed_s = 0; range_s = 0; seeded_s = 0;
		z = '0;
		z.hold_reason = HOLD_DEAD;
		add_row(mk(mx, mx, mx, mx, mx, mx, mx, mx, mx, 0, 65535), 1, z);
		add_row(mk(1000, 2000, -500, 30, -40, 10, 0, 0, 0, 1, 655), 0, z);
		add_row(mk(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1, 65535), 0, z);
		add_row(mk(mn, mn, mn, mn, mn, mn, mn, mn, mn, 1, 65535), 0, z);
		add_row(mk(mx, mn, 0, mn, mx, mx, 0, 0, 0, 1, 65535), 0, z);
		add_row(mk(0, 0, 5000, 100, -100, 20, 1, 1, 1, 1, 65535), 0, z);
		add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 100), 0, z);
		add_row(mk(1, -1, 1, mx, mn, mx, 0, 0, 0, 1, 65535), 0, z);
		add_row(mk(300, 400, 0, -50, 60, 0, 0, 0, 0, 1, 0), 0, z);
		add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(-7000, 3000, mx, 9000, -9000, mn, 0, 0, 0, 1, 30000), 0, z);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (directed[i]) send_word(directed[i].word, directed[i].typed, directed[i].res);
		set_regs(4095, 8388607, 0, 0);
		for (int i = 0; i < 4; i++) send_word(rand_word(), 0, z);
		add_row(mk(10, 10, 10, 1, 1, 1, 0, 0, 0, 0, 1), 0, z);
		send_word(directed[directed.size()-1].word, 0, z);
		set_regs(0, 0, 102944, 205887);
		for (int i = 0; i < 4; i++) send_word(rand_word(), 0, z);
		set_regs(1024, 0, 102944, 205887);
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < RAND_WORDS / 4; i++) send_word(rand_word(), 0, z);
			set_regs($urandom_range(0, 4095),
				($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8388607),
				$urandom_range(0, 102944), $urandom_range(0, 205887));
		end
		settle();
		finished = 1;
		$display("Ran %0d guidance words over six register settings, %0d results checked.",
			words_in, words_out);
		$display("Dead-target holds: %0d, blind-range holds: %0d.", dead_seen, blind_seen);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
